// ===== sv/mrst_pkg.sv =====
package mrst_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_MAX_EDGES    = 2048;
    localparam int VERTEX_W         = 7;
    localparam int WEIGHT_W         = 16;
    localparam int CFG_W            = 7;
    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 7'd2;

    typedef struct packed {
        logic [WEIGHT_W-1:0] w;
        logic [VERTEX_W-1:0] a;
        logic [VERTEX_W-1:0] b;
    } edge_t;

endpackage

// ===== sv/min_range_spanning_tree.sv =====
// Channel   Direction  Contents
// cfg       in         vertex_count, written by the user only while the block is idle, unchecked by the block
// s_axis    in         one edge per transaction, tlast closes the graph
// m_axis    out        one result per graph: tuser = tree_found, tdata = best_range
//
// An edge goes straight into an empty store; otherwise each heavier stored edge is shifted
// up one place, as a read and a write on the edge memory, before the new edge is written.
// The search runs once per start position: it clears the forest, then per edge reads the
// edge, walks the forest nodes for each endpoint and writes a union, and closes with an evaluation.
// After reset the block is idle and empty; a result waiting on m_axis does not
// stop the next graph from loading, only the next result from being presented.
module min_range_spanning_tree
#(
    parameter int MAX_VERTICES = mrst_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = mrst_pkg::DEF_MAX_EDGES
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [mrst_pkg::CFG_W-1:0] cfg_data,    // vertex_count
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,       // end_a, end_b, weight, zero fill
    input  logic                     s_tuser,       // has_edge
    input  logic                     s_tlast,       // last_edge
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,       // best_range
    output logic                     m_tuser        // tree_found
);
    import mrst_pkg::*;

    localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LW = $clog2(MAX_EDGES + 1);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int SW = VW + 1;
    localparam int NW = (SW > VERTEX_W) ? SW : VERTEX_W;

    typedef struct packed {
        logic [VW-1:0] parent;
        logic [SW-1:0] size;
    } node_t;

    typedef enum logic [3:0] {
        IDLE, INS_RD, INS_CMP, INS_PUT, S_START, S_CLR, S_EREAD, S_EDATA,
        FA_RD, FA_DAT, FB_RD, FB_DAT, J1, J2, S_EVAL, DONE
    } state_t;

    state_t state_reg;

    logic [CFG_W-1:0]    vcount_reg;
    logic [LW-1:0]       loaded_reg;
    logic [LW-1:0]       pos_reg;
    logic [LW-1:0]       start_reg;
    logic [LW-1:0]       idx_reg;
    logic [VW-1:0]       ci_reg;
    logic [VW-1:0]       cnt_reg;
    logic [VW-1:0]       x_reg;
    logic [VW-1:0]       ra_reg;
    logic [VW-1:0]       rb_reg;
    logic [SW-1:0]       sa_reg;
    logic [SW-1:0]       sb_reg;
    logic [WEIGHT_W-1:0] lo_reg;
    logic [WEIGHT_W-1:0] hi_reg;
    logic [WEIGHT_W:0]   best_reg;
    edge_t               new_reg;
    edge_t               cur_reg;
    logic                last_reg;
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;
    logic                out_found_reg;

    edge_t edge_mem [MAX_EDGES];
    node_t node_mem [MAX_VERTICES];
    edge_t erd;
    node_t frd;

    logic [EW-1:0] e_raddr, e_waddr;
    logic          e_we;
    edge_t         e_wdata;
    logic [VW-1:0] f_raddr, f_waddr;
    logic          f_we;
    node_t         f_wdata;

    // Saturated vertex count and derived limits.
    logic [NW-1:0] n_sat;
    logic [VW-1:0] n_min1;
    logic          a_ok, b_ok;
    logic [WEIGHT_W-1:0] spread;

    always_comb
    begin
        if (NW'(vcount_reg) < NW'(2))
            n_sat = NW'(2);
        else if (NW'(vcount_reg) > NW'(MAX_VERTICES))
            n_sat = NW'(MAX_VERTICES);
        else
            n_sat = NW'(vcount_reg);
    end

    assign n_min1 = VW'(n_sat - NW'(1));
    assign a_ok   = (erd.a != '0) && (NW'(erd.a) <= n_sat);
    assign b_ok   = (erd.b != '0) && (NW'(erd.b) <= n_sat);
    assign spread = hi_reg - lo_reg;

    always_comb
    begin
        e_raddr = idx_reg[EW-1:0];
        e_waddr = pos_reg[EW-1:0];
        e_we    = 1'b0;
        e_wdata = new_reg;
        f_raddr = x_reg;
        f_waddr = ci_reg;
        f_we    = 1'b0;
        f_wdata = '{parent: ci_reg, size: SW'(1)};
        case (state_reg)
            INS_RD:
            begin
                e_raddr = EW'(pos_reg - LW'(1));
            end
            INS_CMP:
            begin
                e_wdata = erd;
                e_we    = (erd.w > new_reg.w);
            end
            INS_PUT:
            begin
                e_we = 1'b1;
            end
            S_CLR:
            begin
                f_we = 1'b1;
            end
            J1:
            begin
                f_we = 1'b1;
                if (sa_reg > sb_reg)
                begin
                    f_waddr = rb_reg;
                    f_wdata = '{parent: ra_reg, size: sb_reg};
                end
                else
                begin
                    f_waddr = ra_reg;
                    f_wdata = '{parent: rb_reg, size: sa_reg};
                end
            end
            J2:
            begin
                f_we = 1'b1;
                if (sa_reg > sb_reg)
                begin
                    f_waddr = ra_reg;
                    f_wdata = '{parent: ra_reg, size: SW'(sa_reg + sb_reg)};
                end
                else
                begin
                    f_waddr = rb_reg;
                    f_wdata = '{parent: rb_reg, size: SW'(sa_reg + sb_reg)};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (e_we)
            edge_mem[e_waddr] <= e_wdata;
        erd <= edge_mem[e_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
            node_mem[f_waddr] <= f_wdata;
        frd <= node_mem[f_raddr];
    end

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            vcount_reg    <= VERTEX_COUNT_RESET;
            loaded_reg    <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            idx_reg       <= '0;
            ci_reg        <= '0;
            cnt_reg       <= '0;
            x_reg         <= '0;
            ra_reg        <= '0;
            rb_reg        <= '0;
            sa_reg        <= '0;
            sb_reg        <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            new_reg       <= '0;
            cur_reg       <= '0;
            last_reg      <= 1'b0;
            best_reg      <= {1'b1, {WEIGHT_W{1'b0}}};
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
                vcount_reg <= cfg_data;
            if (m_tready && (state_reg != DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        new_reg  <= '{w: s_tdata[29:14], a: s_tdata[6:0], b: s_tdata[13:7]};
                        last_reg <= s_tlast;
                        pos_reg  <= loaded_reg;
                        start_reg <= '0;
                        if (s_tuser && (loaded_reg < LW'(MAX_EDGES)))
                            state_reg <= (loaded_reg == '0) ? INS_PUT : INS_RD;
                        else if (s_tlast)
                            state_reg <= S_START;
                    end
                end
                INS_RD:
                begin
                    state_reg <= INS_CMP;
                end
                INS_CMP:
                begin
                    // The heavier entry is written one place up in this same state.
                    if (erd.w > new_reg.w)
                    begin
                        pos_reg   <= pos_reg - LW'(1);
                        state_reg <= (pos_reg == LW'(1)) ? INS_PUT : INS_RD;
                    end
                    else
                        state_reg <= INS_PUT;
                end
                INS_PUT:
                begin
                    loaded_reg <= loaded_reg + LW'(1);
                    state_reg  <= last_reg ? S_START : IDLE;
                end
                S_START:
                begin
                    if (start_reg >= loaded_reg)
                        state_reg <= DONE;
                    else
                    begin
                        ci_reg    <= '0;
                        idx_reg   <= start_reg;
                        cnt_reg   <= '0;
                        state_reg <= S_CLR;
                    end
                end
                S_CLR:
                begin
                    if (ci_reg == n_min1)
                        state_reg <= S_EREAD;
                    else
                        ci_reg <= ci_reg + VW'(1);
                end
                S_EREAD:
                begin
                    if ((idx_reg < loaded_reg) && (cnt_reg < n_min1))
                        state_reg <= S_EDATA;
                    else
                        state_reg <= S_EVAL;
                end
                S_EDATA:
                begin
                    cur_reg <= erd;
                    if (a_ok && b_ok)
                    begin
                        x_reg     <= VW'(erd.a - VERTEX_W'(1));
                        state_reg <= FA_RD;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + LW'(1);
                        state_reg <= S_EREAD;
                    end
                end
                FA_RD:
                begin
                    state_reg <= FA_DAT;
                end
                FA_DAT:
                begin
                    if (frd.parent == x_reg)
                    begin
                        ra_reg    <= x_reg;
                        sa_reg    <= frd.size;
                        x_reg     <= VW'(cur_reg.b - VERTEX_W'(1));
                        state_reg <= FB_RD;
                    end
                    else
                    begin
                        x_reg     <= frd.parent;
                        state_reg <= FA_RD;
                    end
                end
                FB_RD:
                begin
                    state_reg <= FB_DAT;
                end
                FB_DAT:
                begin
                    if (frd.parent == x_reg)
                    begin
                        rb_reg <= x_reg;
                        sb_reg <= frd.size;
                        if (x_reg == ra_reg)
                        begin
                            idx_reg   <= idx_reg + LW'(1);
                            state_reg <= S_EREAD;
                        end
                        else
                            state_reg <= J1;
                    end
                    else
                    begin
                        x_reg     <= frd.parent;
                        state_reg <= FB_RD;
                    end
                end
                J1:
                begin
                    state_reg <= J2;
                end
                J2:
                begin
                    if (cnt_reg == '0)
                        lo_reg <= cur_reg.w;
                    hi_reg    <= cur_reg.w;
                    cnt_reg   <= cnt_reg + VW'(1);
                    idx_reg   <= idx_reg + LW'(1);
                    state_reg <= S_EREAD;
                end
                S_EVAL:
                begin
                    if (cnt_reg == n_min1)
                    begin
                        if (best_reg[WEIGHT_W] || (spread < best_reg[WEIGHT_W-1:0]))
                            best_reg <= {1'b0, spread};
                    end
                    start_reg <= start_reg + LW'(1);
                    state_reg <= S_START;
                end
                DONE:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= !best_reg[WEIGHT_W];
                        out_data_reg  <= best_reg[WEIGHT_W] ? 16'd0 : best_reg[WEIGHT_W-1:0];
                        loaded_reg    <= '0;
                        best_reg      <= {1'b1, {WEIGHT_W{1'b0}}};
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule
